// ===== hw/rtl/sbme_pkg.sv =====
// sbme_pkg: shared types and fixed constants of the block-matching engine
// used by sbme_div and by the top level sad_block_match_engine
package sbme_pkg;

   // item field widths
   localparam int CMD_W   = 2;
   localparam int COORD_W = 7;
   localparam int LANE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 10;
   localparam int SAD_W   = 20;

   // register widths
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int FS_W       = 6;
   localparam int BPP_W      = 3;
   localparam int COLS_W     = 6;
   localparam int SHIFT_W    = 7;

   // signed working width for window coordinates
   localparam int POS_W = 14;

   // divider step count, one quotient bit per step
   localparam int DIV_STEPS = IDX_W;
   localparam int DIV_CNT_W = 4;

   localparam logic [SAD_W-1:0] SAD_MAX = 20'hFFFFF;

   // commands
   localparam logic [CMD_W-1:0] CMD_LOAD_CUR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_WIN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVAL     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FIELD_SIZE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BYTES_PER_PIX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_COLUMNS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_SHIFT_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_SHIFT_Y  = 3'd4;

   // divider result toward the sequencer
   typedef struct packed {
      logic              done;
      logic [IDX_W-1:0]  quot;
      logic [COLS_W-1:0] rem;
   } div_res_type;

endpackage

// ===== hw/rtl/sbme_div.sv =====
// sbme_div: restoring divider, one quotient bit per cycle
// splits a shift index into row shift (quotient) and column shift (remainder); uses sbme_pkg
module sbme_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sbme_pkg::IDX_W-1:0]  dividend,
   input  logic [sbme_pkg::COLS_W-1:0] divisor,
   output sbme_pkg::div_res_type      res
);
   import sbme_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]     quot_ff, quot_in;
   logic [COLS_W-1:0]    rem_ff, rem_in;
   logic [COLS_W-1:0]    dvs_ff, dvs_in;
   logic [COLS_W:0]      shifted;
   logic [COLS_W+1:0]    trial;

   // one shift-subtract step
   assign shifted = {rem_ff, quot_ff[IDX_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[COLS_W+1]) begin
            rem_in  = trial[COLS_W-1:0];
            quot_in = {quot_ff[IDX_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[COLS_W-1:0];
            quot_in = {quot_ff[IDX_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;
   assign res.rem  = rem_ff;

   // done is a single pulse at the end of a busy run
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a busy run");

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dvs_ff)
      else $error("divider remainder not below divisor");

   a_busy_counts: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with empty step count");

endmodule

// ===== hw/rtl/sad_block_match_engine.sv =====
// sad_block_match_engine: sum-of-absolute-differences block matcher, top level
// byte-serial difference/accumulate loop with two byte memories; uses sbme_pkg, sbme_div
//
// Usage:
//   req_* carries one command item: load a current-block byte, load a search-window
//   byte, or evaluate a shift index. An item is taken when req_valid is high and
//   req_stall is low. rsp_* carries one result (sad, out_of_window) per evaluate,
//   taken when rsp_valid is high and rsp_stall is low. csr_* writes the five
//   registers (field size, bytes per pixel, shift columns, base shifts), always ready.
//   Loads do not stall the request side; the next item may follow at once.
//   An evaluate holds req_stall high while it runs: the divider splits the index,
//   then come a window check, an address setup, one compared byte per cycle (one read
//   port on each memory and one shared subtract/accumulate unit), a drain state
//   and the load into the result register.
//   Out-of-window or out-of-range shifts and zero sizes skip the byte loop.
//   A finished result waits in the output register while rsp_stall is high; the
//   block keeps taking items meanwhile, but a second evaluate holds at its end
//   until the first result has been taken.
//   Reset restores the register defaults and empties the result register; the byte
//   memories are not cleared and hold nothing defined until loaded.
module sad_block_match_engine #(
   parameter int FIELD_MAX       = 32,
   parameter int BPP_MAX         = 4,
   parameter int WINDOW_SIDE     = 128,
   parameter int WINDOW_MARGIN   = 32,
   parameter int SHIFT_INDEX_MAX = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   // command items
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sbme_pkg::CMD_W-1:0]      req_command,
   input  logic [sbme_pkg::COORD_W-1:0]    req_pixel_row,
   input  logic [sbme_pkg::COORD_W-1:0]    req_pixel_column,
   input  logic [sbme_pkg::LANE_W-1:0]     req_byte_lane,
   input  logic [sbme_pkg::BYTE_W-1:0]     req_pixel_byte,
   input  logic [sbme_pkg::IDX_W-1:0]      req_shift_index,
   // result items
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sbme_pkg::SAD_W-1:0]      rsp_sad,
   output logic                           rsp_out_of_window,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sbme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbme_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sbme_pkg::*;

   localparam int C_DEPTH = FIELD_MAX * FIELD_MAX * BPP_MAX;
   localparam int W_DEPTH = WINDOW_SIDE * WINDOW_SIDE * BPP_MAX;
   localparam int CA_W    = $clog2(C_DEPTH);
   localparam int WA_W    = $clog2(W_DEPTH);
   localparam int FW      = $clog2(FIELD_MAX);
   localparam int WIN_W   = $clog2(WINDOW_SIDE);
   localparam int SIW     = $clog2(SHIFT_INDEX_MAX) + 1;
   localparam int FSE_W   = $clog2(FIELD_MAX + 1);
   localparam int SIZE_W  = (FSE_W > FS_W) ? FSE_W : FS_W;

   localparam logic [COORD_W:0]         FIELD_LIM = (COORD_W+1)'(FIELD_MAX);
   localparam logic [COORD_W+1:0]       SIDE_LIM  = (COORD_W+2)'(WINDOW_SIDE);
   localparam logic [LANE_W:0]          LANE_LIM  = (LANE_W+1)'(BPP_MAX);
   localparam logic [SIZE_W-1:0]        FS_CAP    = SIZE_W'(FIELD_MAX);
   localparam logic [BPP_W-1:0]         BPP_CAP   = BPP_W'(BPP_MAX);
   localparam logic [SIW-1:0]           IDX_LIM   = SIW'(SHIFT_INDEX_MAX);
   localparam logic signed [POS_W-1:0]  MARGIN_S  = POS_W'(WINDOW_MARGIN);
   localparam logic signed [POS_W-1:0]  SIDE_S    = POS_W'(WINDOW_SIDE);
   localparam logic [CA_W-1:0]          C_PIX_STEP = CA_W'(BPP_MAX);
   localparam logic [CA_W-1:0]          C_ROW_STEP = CA_W'(FIELD_MAX * BPP_MAX);
   localparam logic [WA_W-1:0]          W_PIX_STEP = WA_W'(BPP_MAX);
   localparam logic [WA_W-1:0]          W_ROW_STEP = WA_W'(WINDOW_SIDE * BPP_MAX);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_CHK   = 7'b0000100,
      ST_SETUP = 7'b0001000,
      ST_RUN   = 7'b0010000,
      ST_DRAIN = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

   // configuration registers
   logic [FS_W-1:0]    field_size_ff;
   logic [BPP_W-1:0]   bpp_ff;
   logic [COLS_W-1:0]  cols_ff;
   logic [SHIFT_W-1:0] base_x_ff;
   logic [SHIFT_W-1:0] base_y_ff;

   // sequencer and datapath registers
   state_type         state_ff, state_in;
   logic              idx_ok_ff, idx_ok_in;
   logic [SAD_W-1:0]  sum_ff, sum_in;
   logic              oow_ff, oow_in;
   logic [WIN_W-1:0]  wx_ff, wx_in;
   logic [WIN_W-1:0]  wy_ff, wy_in;
   logic [CA_W-1:0]   c_row_ff, c_row_in, c_pix_ff, c_pix_in;
   logic [WA_W-1:0]   w_row_ff, w_row_in, w_pix_ff, w_pix_in;
   logic [FW-1:0]     j_ff, j_in, p_ff, p_in;
   logic [LANE_W-1:0] b_ff, b_in;
   logic              rd_vld_ff;
   logic [BYTE_W-1:0] c_q_ff, w_q_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SAD_W-1:0]  rsp_sad_ff;
   logic              rsp_oow_ff;

   // memories
   logic [BYTE_W-1:0] cur_mem [C_DEPTH];
   logic [BYTE_W-1:0] win_mem [W_DEPTH];

   logic              accept, is_eval, cur_we, win_we, out_free, load_rsp;
   logic [CA_W-1:0]   cur_waddr, c_raddr;
   logic [WA_W-1:0]   win_waddr, w_raddr;
   logic [SIZE_W-1:0] fs_eff;
   logic [BPP_W-1:0]  bpp_eff;
   logic [COLS_W-1:0] cols_eff;
   logic signed [POS_W-1:0] wx_s, wy_s, fs_s;
   logic              in_window;
   logic              last_lane, last_pix, last_row;
   logic [BYTE_W-1:0] abs_diff;
   logic [SAD_W:0]    sum_wide;
   div_res_type       div_res;

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign is_eval   = accept && (req_command == CMD_EVAL);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == ST_FIN) && out_free;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         field_size_ff <= FS_W'(16);
         bpp_ff        <= BPP_W'(1);
         cols_ff       <= COLS_W'(32);
         base_x_ff     <= '0;
         base_y_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FIELD_SIZE:    field_size_ff <= csr_wdata[FS_W-1:0];
            REG_BYTES_PER_PIX: bpp_ff        <= csr_wdata[BPP_W-1:0];
            REG_SHIFT_COLUMNS: cols_ff       <= csr_wdata[COLS_W-1:0];
            REG_BASE_SHIFT_X:  base_x_ff     <= csr_wdata[SHIFT_W-1:0];
            REG_BASE_SHIFT_Y:  base_y_ff     <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped sizes
   assign fs_eff   = (SIZE_W'(field_size_ff) > FS_CAP) ? FS_CAP : SIZE_W'(field_size_ff);
   assign bpp_eff  = (bpp_ff > BPP_CAP) ? BPP_CAP : bpp_ff;
   assign cols_eff = (cols_ff == '0) ? COLS_W'(1) : cols_ff;

   // load addressing, out-of-store loads are dropped
   assign cur_we = accept && (req_command == CMD_LOAD_CUR) &&
                   ({1'b0, req_pixel_row} < FIELD_LIM) &&
                   ({1'b0, req_pixel_column} < FIELD_LIM) &&
                   ({1'b0, req_byte_lane} < LANE_LIM);
   assign win_we = accept && (req_command == CMD_LOAD_WIN) &&
                   ({2'b00, req_pixel_row} < SIDE_LIM) &&
                   ({2'b00, req_pixel_column} < SIDE_LIM) &&
                   ({1'b0, req_byte_lane} < LANE_LIM);
   assign cur_waddr = (CA_W'(req_pixel_row) * CA_W'(FIELD_MAX) + CA_W'(req_pixel_column))
                      * CA_W'(BPP_MAX) + CA_W'(req_byte_lane);
   assign win_waddr = (WA_W'(req_pixel_row) * WA_W'(WINDOW_SIDE)
                      + WA_W'(req_pixel_column)) * WA_W'(BPP_MAX) + WA_W'(req_byte_lane);

   // read addresses of the byte loop
   assign c_raddr = c_pix_ff + CA_W'(b_ff);
   assign w_raddr = w_pix_ff + WA_W'(b_ff);

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= req_pixel_byte;
      end
      c_q_ff <= cur_mem[c_raddr];
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_waddr] <= req_pixel_byte;
      end
      w_q_ff <= win_mem[w_raddr];
   end

   // index split into column and row shift
   sbme_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (is_eval),
      .dividend (req_shift_index),
      .divisor  (cols_eff),
      .res      (div_res)
   );

   // window position and bounds
   assign wx_s = MARGIN_S + POS_W'(signed'(base_x_ff)) + $signed(POS_W'(div_res.rem));
   assign wy_s = MARGIN_S + POS_W'(signed'(base_y_ff)) + $signed(POS_W'(div_res.quot));
   assign fs_s = $signed(POS_W'(fs_eff));
   assign in_window = idx_ok_ff && (wx_s >= 0) && (wy_s >= 0) &&
                      (wx_s + fs_s <= SIDE_S) && (wy_s + fs_s <= SIDE_S);

   // loop end conditions
   assign last_lane = ({1'b0, b_ff} == bpp_eff - 1'b1);
   assign last_pix  = (SIZE_W'(p_ff) == fs_eff - 1'b1);
   assign last_row  = (SIZE_W'(j_ff) == fs_eff - 1'b1);

   // shared absolute difference and saturating accumulate
   assign abs_diff = (c_q_ff > w_q_ff) ? (c_q_ff - w_q_ff) : (w_q_ff - c_q_ff);
   assign sum_wide = {1'b0, sum_ff} + (SAD_W+1)'(abs_diff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      idx_ok_in = idx_ok_ff;
      sum_in    = sum_ff;
      oow_in    = oow_ff;
      wx_in     = wx_ff;
      wy_in     = wy_ff;
      c_row_in  = c_row_ff;
      c_pix_in  = c_pix_ff;
      w_row_in  = w_row_ff;
      w_pix_in  = w_pix_ff;
      j_in      = j_ff;
      p_in      = p_ff;
      b_in      = b_ff;

      if (rd_vld_ff) begin
         sum_in = sum_wide[SAD_W] ? SAD_MAX : sum_wide[SAD_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (is_eval) begin
               idx_ok_in = (SIW'(req_shift_index) < IDX_LIM);
               sum_in    = '0;
               oow_in    = 1'b0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            wx_in = wx_s[WIN_W-1:0];
            wy_in = wy_s[WIN_W-1:0];
            if (!in_window) begin
               oow_in   = 1'b1;
               state_in = ST_FIN;
            end else if ((fs_eff == '0) || (bpp_eff == '0)) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            w_row_in = (WA_W'(wy_ff) * WA_W'(WINDOW_SIDE) + WA_W'(wx_ff)) * WA_W'(BPP_MAX);
            w_pix_in = w_row_in;
            c_row_in = '0;
            c_pix_in = '0;
            j_in     = '0;
            p_in     = '0;
            b_in     = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (!last_lane) begin
               b_in = b_ff + 1'b1;
            end else begin
               b_in = '0;
               if (!last_pix) begin
                  p_in     = p_ff + 1'b1;
                  c_pix_in = c_pix_ff + C_PIX_STEP;
                  w_pix_in = w_pix_ff + W_PIX_STEP;
               end else if (!last_row) begin
                  p_in     = '0;
                  j_in     = j_ff + 1'b1;
                  c_row_in = c_row_ff + C_ROW_STEP;
                  w_row_in = w_row_ff + W_ROW_STEP;
                  c_pix_in = c_row_in;
                  w_pix_in = w_row_in;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == ST_RUN);
      end
   end

   always_ff @(posedge clock) begin
      idx_ok_ff <= idx_ok_in;
      sum_ff    <= sum_in;
      oow_ff    <= oow_in;
      wx_ff     <= wx_in;
      wy_ff     <= wy_in;
      c_row_ff  <= c_row_in;
      c_pix_ff  <= c_pix_in;
      w_row_ff  <= w_row_in;
      w_pix_ff  <= w_pix_in;
      j_ff      <= j_in;
      p_ff      <= p_in;
      b_ff      <= b_in;
   end

   // result register
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_sad_ff <= sum_ff;
         rsp_oow_ff <= oow_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sad           = rsp_sad_ff;
   assign rsp_out_of_window = rsp_oow_ff;

   // a result outside the window always carries a zero sum
   a_oow_zero_sad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_oow_ff |-> rsp_sad_ff == '0)
      else $error("out-of-window result with nonzero sad");

   // memory data is only accumulated right after a loop cycle
   a_read_from_run: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == ST_RUN))
      else $error("accumulate without a loop read");

   // the sum never falls while bytes are accumulated
   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |=> sum_ff >= $past(sum_ff))
      else $error("sad accumulator decreased");

   // a finished evaluate reaches the result register
   a_fin_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished evaluate not delivered");

   // the loop only runs on a shift that lies in the window
   a_run_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |-> !oow_ff && idx_ok_ff)
      else $error("byte loop started outside the window");

endmodule

// ===== verif/sad_block_match_checker.sv =====
// sad_block_match_checker: watches the command, result and register channels of
// sad_block_match_engine, predicts each match result and compares it; uses sbme_pkg
module sad_block_match_checker
   import sbme_pkg::*;
#(
   parameter int FIELD_MAX       = 32,
   parameter int BPP_MAX         = 4,
   parameter int WINDOW_SIDE     = 128,
   parameter int WINDOW_MARGIN   = 32,
   parameter int SHIFT_INDEX_MAX = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [COORD_W-1:0]    req_pixel_row,
   input  logic [COORD_W-1:0]    req_pixel_column,
   input  logic [LANE_W-1:0]     req_byte_lane,
   input  logic [BYTE_W-1:0]     req_pixel_byte,
   input  logic [IDX_W-1:0]      req_shift_index,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [SAD_W-1:0]      rsp_sad,
   input  logic                  rsp_out_of_window,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SAD_W-1:0] sad;
      logic             out_of_window;
   } match_result_t;

   localparam int CUR_BYTES = FIELD_MAX * FIELD_MAX * BPP_MAX;
   localparam int WIN_BYTES = WINDOW_SIDE * WINDOW_SIDE * BPP_MAX;

   // own copy of the byte stores and the registers
   logic [BYTE_W-1:0]         cur_bytes [CUR_BYTES];
   logic [BYTE_W-1:0]         win_bytes [WIN_BYTES];
   logic [FS_W-1:0]           fs_reg;
   logic [BPP_W-1:0]          bpp_reg;
   logic [COLS_W-1:0]         cols_reg;
   logic signed [SHIFT_W-1:0] shift_x_reg;
   logic signed [SHIFT_W-1:0] shift_y_reg;
   match_result_t             owed_results [$];
   int                        error_count = 0;

   initial begin
      mismatches   = 0;
      results_owed = 0;
   end

   // sum of absolute byte differences at one shift index
   function automatic match_result_t sad_at_shift(input logic [IDX_W-1:0] shift_idx);
      int fs, bpp, cols, wx, wy, sum, c, w;
      match_result_t r;
      fs   = (fs_reg > FIELD_MAX) ? FIELD_MAX : int'(fs_reg);
      bpp  = (bpp_reg > BPP_MAX) ? BPP_MAX : int'(bpp_reg);
      cols = (cols_reg == 0) ? 1 : int'(cols_reg);
      r.sad = '0;
      r.out_of_window = 1'b1;
      if (shift_idx >= SHIFT_INDEX_MAX)
         return r;
      wx = WINDOW_MARGIN + int'(shift_x_reg) + int'(shift_idx) % cols;
      wy = WINDOW_MARGIN + int'(shift_y_reg) + int'(shift_idx) / cols;
      // a block that leaves the window is flagged and summed as zero
      if (wx < 0 || wy < 0 || wx + fs > WINDOW_SIDE || wy + fs > WINDOW_SIDE)
         return r;
      sum = 0;
      for (int j = 0; j < fs; j++) begin
         for (int p = 0; p < fs; p++) begin
            for (int b = 0; b < bpp; b++) begin
               c = cur_bytes[(j * FIELD_MAX + p) * BPP_MAX + b];
               w = win_bytes[((wy + j) * WINDOW_SIDE + wx + p) * BPP_MAX + b];
               sum += (c > w) ? c - w : w - c;
               if (sum > SAD_MAX)
                  sum = SAD_MAX;
            end
         end
      end
      r.sad = SAD_W'(sum);
      r.out_of_window = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      match_result_t want;
      if (reset) begin
         fs_reg      = 6'd16;
         bpp_reg     = 3'd1;
         cols_reg    = 6'd32;
         shift_x_reg = '0;
         shift_y_reg = '0;
         owed_results.delete();
      end else begin
         // result items against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $error("result item with none owed: sad %0d out_of_window %0b",
                      rsp_sad, rsp_out_of_window);
               error_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_sad !== want.sad) begin
                  $error("sad: expected %0d, got %0d", want.sad, rsp_sad);
                  error_count++;
               end
               if (rsp_out_of_window !== want.out_of_window) begin
                  $error("out_of_window: expected %0b, got %0b",
                         want.out_of_window, rsp_out_of_window);
                  error_count++;
               end
            end
         end
         // command items: loads update the stores, evaluates owe a result
         if (req_valid && !req_stall) begin
            case (req_command)
               CMD_LOAD_CUR: begin
                  if (req_pixel_row < FIELD_MAX && req_pixel_column < FIELD_MAX &&
                      req_byte_lane < BPP_MAX)
                     cur_bytes[(int'(req_pixel_row) * FIELD_MAX + int'(req_pixel_column))
                               * BPP_MAX + int'(req_byte_lane)] = req_pixel_byte;
               end
               CMD_LOAD_WIN: begin
                  if (req_pixel_row < WINDOW_SIDE && req_pixel_column < WINDOW_SIDE &&
                      req_byte_lane < BPP_MAX)
                     win_bytes[(int'(req_pixel_row) * WINDOW_SIDE + int'(req_pixel_column))
                               * BPP_MAX + int'(req_byte_lane)] = req_pixel_byte;
               end
               CMD_EVAL: owed_results.push_back(sad_at_shift(req_shift_index));
               default: ;
            endcase
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FIELD_SIZE:    fs_reg      = csr_wdata[FS_W-1:0];
               REG_BYTES_PER_PIX: bpp_reg     = csr_wdata[BPP_W-1:0];
               REG_SHIFT_COLUMNS: cols_reg    = csr_wdata[COLS_W-1:0];
               REG_BASE_SHIFT_X:  shift_x_reg = csr_wdata;
               REG_BASE_SHIFT_Y:  shift_y_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatches   <= error_count;
      results_owed <= owed_results.size();
   end

endmodule

// ===== verif/sad_block_match_engine_test.sv =====
// sad_block_match_engine_test: clock, reset, stimulus and verdict for the matcher
// depends on sbme_pkg, sad_block_match_engine and sad_block_match_checker
module sad_block_match_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sbme_pkg::*;

   localparam int FIELD_MAX       = 32;
   localparam int BPP_MAX         = 4;
   localparam int WINDOW_SIDE     = 128;
   localparam int WINDOW_MARGIN   = 32;
   localparam int SHIFT_INDEX_MAX = 1024;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 600;
   localparam int CALM_CYCLES   = 1500;
   localparam int RANDOM_ITEMS  = 1400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command = '0;
   logic [COORD_W-1:0]    req_pixel_row = '0;
   logic [COORD_W-1:0]    req_pixel_column = '0;
   logic [LANE_W-1:0]     req_byte_lane = '0;
   logic [BYTE_W-1:0]     req_pixel_byte = '0;
   logic [IDX_W-1:0]      req_shift_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SAD_W-1:0]      rsp_sad;
   logic                  rsp_out_of_window;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    mismatches;
   int                    results_owed;

   // bytes already loaded, so that no evaluate reads an unwritten byte
   bit cur_known [FIELD_MAX * FIELD_MAX * BPP_MAX];
   bit win_known [WINDOW_SIDE * WINDOW_SIDE * BPP_MAX];

   // register settings as last written
   int cfg_fs = 16, cfg_bpp = 1, cfg_cols = 32, cfg_bx = 0, cfg_by = 0;

   bit calm = 1'b0;
   bit pressure_go = 1'b0;

   always #6 clock = ~clock;

   sad_block_match_engine u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_pixel_row     (req_pixel_row),
      .req_pixel_column  (req_pixel_column),
      .req_byte_lane     (req_byte_lane),
      .req_pixel_byte    (req_pixel_byte),
      .req_shift_index   (req_shift_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sad           (rsp_sad),
      .rsp_out_of_window (rsp_out_of_window),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   sad_block_match_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_pixel_row     (req_pixel_row),
      .req_pixel_column  (req_pixel_column),
      .req_byte_lane     (req_byte_lane),
      .req_pixel_byte    (req_pixel_byte),
      .req_shift_index   (req_shift_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sad           (rsp_sad),
      .rsp_out_of_window (rsp_out_of_window),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatches        (mismatches),
      .results_owed      (results_owed)
   );

   // offer one command item, with random gaps unless in a calm stretch
   task automatic push_item(input logic [CMD_W-1:0] cmd, input int row, col, lane, pix, idx);
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_pixel_row    <= COORD_W'(row);
      req_pixel_column <= COORD_W'(col);
      req_byte_lane    <= LANE_W'(lane);
      req_pixel_byte   <= BYTE_W'(pix);
      req_shift_index  <= IDX_W'(idx);
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic load_byte(input logic [CMD_W-1:0] cmd, input int row, col, lane, pix);
      if (cmd == CMD_LOAD_CUR && row < FIELD_MAX && col < FIELD_MAX && lane < BPP_MAX)
         cur_known[(row * FIELD_MAX + col) * BPP_MAX + lane] = 1'b1;
      else if (cmd == CMD_LOAD_WIN && row < WINDOW_SIDE && col < WINDOW_SIDE &&
               lane < BPP_MAX)
         win_known[(row * WINDOW_SIDE + col) * BPP_MAX + lane] = 1'b1;
      push_item(cmd, row, col, lane, pix, $urandom_range(0, 1023));
   endtask

   // load whatever bytes an in-window shift would read and nobody wrote yet
   task automatic cover_shift(input int idx);
      int fs, bpp, cols, wx, wy;
      fs   = (cfg_fs > FIELD_MAX) ? FIELD_MAX : cfg_fs;
      bpp  = (cfg_bpp > BPP_MAX) ? BPP_MAX : cfg_bpp;
      cols = (cfg_cols == 0) ? 1 : cfg_cols;
      wx = WINDOW_MARGIN + cfg_bx + idx % cols;
      wy = WINDOW_MARGIN + cfg_by + idx / cols;
      if (idx >= SHIFT_INDEX_MAX || wx < 0 || wy < 0 ||
          wx + fs > WINDOW_SIDE || wy + fs > WINDOW_SIDE)
         return;
      for (int j = 0; j < fs; j++) begin
         for (int p = 0; p < fs; p++) begin
            for (int b = 0; b < bpp; b++) begin
               if (!cur_known[(j * FIELD_MAX + p) * BPP_MAX + b])
                  load_byte(CMD_LOAD_CUR, j, p, b, $urandom_range(0, 255));
               if (!win_known[((wy + j) * WINDOW_SIDE + wx + p) * BPP_MAX + b])
                  load_byte(CMD_LOAD_WIN, wy + j, wx + p, b, $urandom_range(0, 255));
            end
         end
      end
   endtask

   task automatic eval_shift(input int idx);
      cover_shift(idx);
      push_item(CMD_EVAL, $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 3), $urandom_range(0, 255), idx);
   endtask

   // wait until every owed result is back and the engine has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all five registers back to back
   task automatic set_regs(input int fs, bpp, cols, bx, by);
      logic [CSR_DATA_W-1:0] vals [5];
      logic [CSR_IDX_W-1:0]  reg_ids [5];
      reg_ids = '{REG_FIELD_SIZE, REG_BYTES_PER_PIX, REG_SHIFT_COLUMNS,
                  REG_BASE_SHIFT_X, REG_BASE_SHIFT_Y};
      vals = '{CSR_DATA_W'(fs), CSR_DATA_W'(bpp), CSR_DATA_W'(cols),
               CSR_DATA_W'(bx), CSR_DATA_W'(by)};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_ids[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
      end
      csr_valid <= 1'b0;
      cfg_fs   = fs & 63;
      cfg_bpp  = bpp & 7;
      cfg_cols = cols & 63;
      cfg_bx   = bx;
      cfg_by   = by;
   endtask

   // mostly small blocks; now and then the full size or out-of-range settings
   task automatic random_regs();
      int pick, fs, bpp, bx, by;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         fs = $urandom_range(9, 32);
      else if (pick < 8)
         fs = $urandom_range(0, 63);
      else
         fs = $urandom_range(1, 8);
      bpp = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      if ($urandom_range(0, 99) < 90) begin
         bx = int'($urandom_range(0, 64)) - 32;
         by = int'($urandom_range(0, 64)) - 32;
      end else begin
         bx = int'($urandom_range(0, 127)) - 64;
         by = int'($urandom_range(0, 127)) - 64;
      end
      set_regs(fs, bpp, $urandom_range(0, 63), bx, by);
   endtask

   // one random item; ignored loads and the unused command are not counted
   task automatic random_item(output bit counted);
      int pick, cols, hi;
      pick = $urandom_range(0, 99);
      counted = 1'b1;
      if (pick < 45) begin
         cols = (cfg_cols == 0) ? 1 : cfg_cols;
         hi = (cols * 48 > 1023) ? 1023 : cols * 48;
         eval_shift(($urandom_range(0, 99) < 70) ? $urandom_range(0, hi)
                                                 : $urandom_range(0, 1023));
      end else if (pick < 70) begin
         load_byte(CMD_LOAD_WIN, $urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom_range(0, 3), $urandom_range(0, 255));
      end else if (pick < 88) begin
         load_byte(CMD_LOAD_CUR, $urandom_range(0, FIELD_MAX - 1),
                   $urandom_range(0, FIELD_MAX - 1), $urandom_range(0, 3),
                   $urandom_range(0, 255));
      end else if (pick < 95) begin
         load_byte(CMD_LOAD_CUR, $urandom_range(FIELD_MAX, 127), $urandom_range(0, 127),
                   $urandom_range(0, 3), $urandom_range(0, 255));
         counted = 1'b0;
      end else begin
         push_item(CMD_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 1023));
         counted = 1'b0;
      end
   endtask

   // result side: random stalls, one long hold-off, then a stretch with none
   initial begin : result_sink
      int hold_left, calm_left;
      bit held;
      hold_left = 0;
      calm_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && pressure_go) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
            if (hold_left == 0)
               calm_left = CALM_CYCLES;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 33);
         end
      end
   end

   // ends the run when no channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL sad_block_match_engine");
      $finish;
   end

   initial begin : stimulus
      int random_done, seg_len;
      bit counted;
      random_done = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, unused command, ignored loads, store corners
      push_item(CMD_UNUSED, 0, 0, 0, 8'hA5, 1023);
      load_byte(CMD_LOAD_CUR, FIELD_MAX, 0, 0, 255);
      load_byte(CMD_LOAD_CUR, 0, 127, 3, 0);
      load_byte(CMD_LOAD_WIN, 127, 127, 3, 255);
      load_byte(CMD_LOAD_CUR, FIELD_MAX - 1, FIELD_MAX - 1, 3, 0);
      load_byte(CMD_LOAD_CUR, 0, 0, 0, 255);
      eval_shift(0);
      eval_shift(1023);

      // zero field size, in window and far outside
      settle();
      set_regs(0, 1, 32, 0, 0);
      eval_shift(0);
      eval_shift(1023);
      settle();
      set_regs(0, 1, 32, -64, -64);
      eval_shift(5);

      // oversized size and bytes, zero columns, extreme base shifts
      settle();
      set_regs(63, 7, 0, 63, -64);
      eval_shift(0);
      eval_shift(1023);

      // zero bytes per pixel, widest column count
      settle();
      set_regs(1, 0, 63, 0, 0);
      eval_shift(100);
      eval_shift(1023);

      // full-size block at the window's top-left corner
      settle();
      set_regs(32, 4, 1, -32, -32);
      eval_shift(0);
      eval_shift(1);

      // full-size block on the bottom edge, then one row past it
      settle();
      set_regs(32, 4, 1, 32, 32);
      eval_shift(32);
      eval_shift(33);

      // one column left of the window
      settle();
      set_regs(4, 2, 8, -33, 0);
      eval_shift(0);

      // random segments, each under its own register setting
      while (random_done < RANDOM_ITEMS) begin
         settle();
         random_regs();
         seg_len = $urandom_range(30, 80);
         for (int k = 0; k < seg_len && random_done < RANDOM_ITEMS; k++) begin
            calm = (random_done >= 300 && random_done < 450);
            if (random_done >= 100)
               pressure_go = 1'b1;
            random_item(counted);
            if (counted)
               random_done++;
         end
      end
      calm = 1'b0;

      settle();
      if (mismatches == 0 && results_owed == 0) begin
         $display("PASS sad_block_match_engine");
      end else begin
         $display("FAIL sad_block_match_engine");
      end
      $finish;
   end

endmodule
